// ----- hdl/tcpo_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpo_pkg
// Shared types and constants for the TCP option parser: word formats,
// option kinds and legal sizes, parse phases and the per-segment snapshot.
// ----------------------------------------------------------------------------
package tcpo_pkg;

  // payload staging and held sack slots
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = 5;
  localparam int SACK_SLOTS  = 4;
  localparam int SLOT_AW     = 2;
  localparam int PCNT_W      = 6;
  localparam int SCNT_W      = 3;

  // segment queue between parser and record emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // option kinds
  localparam logic [7:0] KIND_EOL     = 8'd0;
  localparam logic [7:0] KIND_NOP     = 8'd1;
  localparam logic [7:0] KIND_MSS     = 8'd2;
  localparam logic [7:0] KIND_WSCALE  = 8'd3;
  localparam logic [7:0] KIND_SACK_OK = 8'd4;
  localparam logic [7:0] KIND_SACK    = 8'd5;
  localparam logic [7:0] KIND_TSTAMP  = 8'd8;

  // legal option sizes
  localparam logic [7:0] SIZE_MIN      = 8'd2;
  localparam logic [7:0] SIZE_MSS      = 8'd4;
  localparam logic [7:0] SIZE_WSCALE   = 8'd3;
  localparam logic [7:0] SIZE_SACK_OK  = 8'd2;
  localparam logic [7:0] SIZE_SACK_MIN = 8'd10;
  localparam logic [7:0] SIZE_TSTAMP   = 8'd10;

  localparam logic [7:0] SHIFT_MAX = 8'd14;

  // record kinds
  localparam logic REC_SUMMARY = 1'b0;
  localparam logic REC_BLOCK   = 1'b1;

  typedef enum logic [1:0] {
    PH_KIND,
    PH_SIZE,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       last_byte;
    logic       no_options;
  } opt_word_t;

  typedef struct packed {
    logic        record_kind;
    logic [15:0] mss;
    logic [3:0]  window_shift;
    logic        sack_permitted;
    logic [2:0]  sack_count;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic [31:0] block_start;
    logic [31:0] block_end;
    logic        final_record;
  } rec_word_t;

  // option finished and/or area closed, handed from parser to hold stage
  typedef struct packed {
    logic       commit;
    logic       close;
    logic [7:0] kind;
    logic [7:0] size;
  } opt_event_t;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  // everything held for one segment at the end of its option area
  typedef struct packed {
    logic [15:0]                      mss;
    logic [3:0]                       window_shift;
    logic                             sack_permitted;
    logic [SCNT_W-1:0]                sack_count;
    logic [31:0]                      ts_value;
    logic [31:0]                      ts_echo;
    logic [SACK_SLOTS-1:0][31:0]      block_start;
    logic [SACK_SLOTS-1:0][31:0]      block_end;
  } seg_t;

endpackage

// ----- hdl/tcpo_parse.sv -----
// ----------------------------------------------------------------------------
// tcpo_parse
// Front stage: walks the option area one byte per cycle while bytes are accepted,
// stages option payload bytes and flags finished options and the end of the area.
// ----------------------------------------------------------------------------
module tcpo_parse #(
  parameter int MAX_AREA_BYTES = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 stall,
  input  tcpo_pkg::opt_word_t  opt,
  output tcpo_pkg::opt_event_t ev,
  output tcpo_pkg::store_t     store
);
  import tcpo_pkg::*;

  localparam int AW = $clog2(MAX_AREA_BYTES + 1);

  phase_t            phase, phase_next;
  logic [7:0]        kind, kind_next;
  logic [7:0]        size, size_next;
  logic [PCNT_W-1:0] pcnt, pcnt_next, pcnt_inc;
  logic [AW-1:0]     acnt, acnt_next;
  opt_event_t        ev_next;
  logic              take, close, pay_done, store_we;
  logic [7:0]        b;

  // byte qualification
  assign b        = opt.option_byte;
  assign take     = accept && !opt.no_options && (acnt < AW'(MAX_AREA_BYTES));
  assign close    = accept && (opt.no_options || opt.last_byte);
  assign pcnt_inc = pcnt + PCNT_W'(1);
  assign pay_done = ({2'b00, pcnt_inc} + SIZE_MIN) == size;

  // next parse phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        PH_KIND: begin
          if (b == KIND_EOL) phase_next = PH_STOPPED;
          else if (b != KIND_NOP) phase_next = PH_SIZE;
        end
        PH_SIZE: begin
          if (b < SIZE_MIN) phase_next = PH_STOPPED;
          else if (b == SIZE_MIN) phase_next = PH_KIND;
          else phase_next = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pay_done) phase_next = PH_KIND;
        end
        default: phase_next = phase;
      endcase
    end
    if (close) phase_next = PH_KIND;
  end

  // option fields, counters and events
  always_comb begin
    kind_next = kind;
    size_next = size;
    pcnt_next = pcnt;
    acnt_next = acnt;
    ev_next   = '0;
    store_we  = 1'b0;
    if (take) begin
      acnt_next = acnt + AW'(1);
      case (phase)
        PH_KIND: begin
          if (b != KIND_EOL && b != KIND_NOP) kind_next = b;
        end
        PH_SIZE: begin
          size_next = b;
          pcnt_next = '0;
          if (b == SIZE_MIN) begin
            ev_next.commit = 1'b1;
            ev_next.kind   = kind;
            ev_next.size   = b;
          end
        end
        PH_PAYLOAD: begin
          store_we  = !pcnt[PCNT_W-1];
          pcnt_next = pcnt_inc;
          if (pay_done) begin
            ev_next.commit = 1'b1;
            ev_next.kind   = kind;
            ev_next.size   = size;
          end
        end
        default: ;
      endcase
    end
    if (close) begin
      ev_next.close = 1'b1;
      kind_next     = '0;
      size_next     = '0;
      pcnt_next     = '0;
      acnt_next     = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_KIND;
      kind  <= '0;
      size  <= '0;
      pcnt  <= '0;
      acnt  <= '0;
      ev    <= '0;
    end else begin
      phase <= phase_next;
      kind  <= kind_next;
      size  <= size_next;
      pcnt  <= pcnt_next;
      acnt  <= acnt_next;
      if (!stall) ev <= ev_next;
    end
  end

  // payload staging, read by the hold stage in the cycle after the write
  always_ff @(posedge clk) begin
    if (store_we) store[pcnt[STORE_AW-1:0]] <= b;
  end

endmodule

// ----- hdl/tcpo_hold.sv -----
// ----------------------------------------------------------------------------
// tcpo_hold
// Commits finished options into the held values and, at the end of the
// area, pushes the segment snapshot and clears the held values.
// ----------------------------------------------------------------------------
module tcpo_hold #(
  parameter int MAX_SACK_BLOCKS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcpo_pkg::opt_event_t ev,
  input  tcpo_pkg::store_t     store,
  input  logic                 q_full,
  output logic                 stall,
  output logic                 push,
  output tcpo_pkg::seg_t       seg
);
  import tcpo_pkg::*;

  seg_t              held, held_next;
  logic [7:0]        sz_m2;
  logic [4:0]        nraw;
  logic [SCNT_W-1:0] nblk;
  logic              sack_legal;

  function automatic logic [31:0] be32(input store_t s, input logic [STORE_AW-1:0] pos);
    be32 = {s[pos], s[pos + STORE_AW'(1)], s[pos + STORE_AW'(2)], s[pos + STORE_AW'(3)]};
  endfunction

  // sack block count from option size
  assign sz_m2      = ev.size - SIZE_MIN;
  assign nraw       = sz_m2[7:3];
  assign nblk       = (nraw > 5'(MAX_SACK_BLOCKS)) ? SCNT_W'(MAX_SACK_BLOCKS) : nraw[2:0];
  assign sack_legal = (ev.size >= SIZE_SACK_MIN) && (sz_m2[2:0] == 3'b000);

  // apply a finished option
  always_comb begin
    held_next = held;
    if (ev.commit) begin
      case (ev.kind)
        KIND_MSS: begin
          if (ev.size == SIZE_MSS) held_next.mss = {store[0], store[1]};
        end
        KIND_WSCALE: begin
          if (ev.size == SIZE_WSCALE)
            held_next.window_shift = (store[0] > SHIFT_MAX) ? SHIFT_MAX[3:0] : store[0][3:0];
        end
        KIND_SACK_OK: begin
          if (ev.size == SIZE_SACK_OK) held_next.sack_permitted = 1'b1;
        end
        KIND_SACK: begin
          if (sack_legal) begin
            held_next.sack_count = nblk;
            for (int i = 0; i < SACK_SLOTS; i++) begin
              if (SCNT_W'(i) < nblk) begin
                held_next.block_start[i] = be32(store, STORE_AW'(i * 8));
                held_next.block_end[i]   = be32(store, STORE_AW'(i * 8 + 4));
              end
            end
          end
        end
        KIND_TSTAMP: begin
          if (ev.size == SIZE_TSTAMP) begin
            held_next.ts_value = be32(store, STORE_AW'(0));
            held_next.ts_echo  = be32(store, STORE_AW'(4));
          end
        end
        default: ;
      endcase
    end
  end

  // snapshot handoff
  assign stall = ev.close && q_full;
  assign push  = ev.close && !q_full;
  assign seg   = held_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (!stall) begin
      held <= ev.close ? '0 : held_next;
    end
  end

endmodule

// ----- hdl/tcpo_queue.sv -----
// ----------------------------------------------------------------------------
// tcpo_queue
// Short queue of segment snapshots between the parser and the emitter.
// ----------------------------------------------------------------------------
module tcpo_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcpo_pkg::seg_t wdata,
  input  logic           pop,
  output tcpo_pkg::seg_t head,
  output logic           q_full,
  output logic           q_empty
);
  import tcpo_pkg::*;

  seg_t                entry [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   cnt;
  logic                do_push, do_pop;

  assign q_full  = (cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign q_empty = (cnt == '0);
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;
  assign head    = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + (QUEUE_AW + 1)'(1);
        2'b01:   cnt <= cnt - (QUEUE_AW + 1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= wdata;
  end

endmodule

// ----- hdl/tcpo_back.sv -----
// ----------------------------------------------------------------------------
// tcpo_back
// Back stage: turns the oldest segment snapshot into one summary word and
// then one word per held sack block.
// ----------------------------------------------------------------------------
module tcpo_back (
  input  logic                clk,
  input  logic                rst,
  input  tcpo_pkg::seg_t      head,
  input  logic                q_empty,
  input  logic                pop,
  output logic                q_pop,
  output logic                empty,
  output tcpo_pkg::rec_word_t rec
);
  import tcpo_pkg::*;

  logic [SCNT_W-1:0]  idx;
  logic [SCNT_W-1:0]  slot_raw;
  logic [SLOT_AW-1:0] slot;
  logic               is_final;

  assign empty    = q_empty;
  assign is_final = (idx == head.sack_count);
  assign slot_raw = idx - SCNT_W'(1);
  assign slot     = slot_raw[SLOT_AW-1:0];
  assign q_pop    = pop && !q_empty && is_final;

  // record word for the current position
  always_comb begin
    rec              = '0;
    rec.final_record = is_final;
    if (idx == '0) begin
      rec.record_kind    = REC_SUMMARY;
      rec.mss            = head.mss;
      rec.window_shift   = head.window_shift;
      rec.sack_permitted = head.sack_permitted;
      rec.sack_count     = head.sack_count;
      rec.ts_value       = head.ts_value;
      rec.ts_echo        = head.ts_echo;
    end else begin
      rec.record_kind = REC_BLOCK;
      rec.block_start = head.block_start[slot];
      rec.block_end   = head.block_end[slot];
    end
  end

  // position within the current segment
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && !q_empty) begin
      idx <= is_final ? '0 : idx + SCNT_W'(1);
    end
  end

endmodule

// ----- hdl/tcp_option_parser_unit.sv -----
// a last byte accepted is registered in the parser event register, then written
// into the snapshot queue, from which the emitter forms its summary word; one
// byte is taken every cycle while the queue has room. each segment leaves as one
// summary word plus one word per sack block (1 to 5 words); the snapshot queue holds 2 segments.
// reset: synchronous, clears the parser, held option values and the queue.
// ----------------------------------------------------------------------------
// tcp_option_parser_unit
// TCP option area parser: option bytes in, summary and sack block words out.
// ----------------------------------------------------------------------------
module tcp_option_parser_unit #(
  parameter int MAX_SACK_BLOCKS = 4,
  parameter int MAX_AREA_BYTES  = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tcpo_pkg::opt_word_t opt,
  output logic                empty,
  input  logic                pop,
  output tcpo_pkg::rec_word_t rec
);
  import tcpo_pkg::*;

  opt_event_t ev;
  store_t     store;
  seg_t       seg, head;
  logic       stall, seg_push, q_full, q_empty, q_pop, accept;

  assign full   = stall;
  assign accept = push && !stall;

  // front: byte parser
  tcpo_parse #(
    .MAX_AREA_BYTES(MAX_AREA_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .stall (stall),
    .opt   (opt),
    .ev    (ev),
    .store (store)
  );

  // front: held option values
  tcpo_hold #(
    .MAX_SACK_BLOCKS(MAX_SACK_BLOCKS)
  ) u_hold (
    .clk   (clk),
    .rst   (rst),
    .ev    (ev),
    .store (store),
    .q_full(q_full),
    .stall (stall),
    .push  (seg_push),
    .seg   (seg)
  );

  // segment snapshot queue
  tcpo_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (seg_push),
    .wdata  (seg),
    .pop    (q_pop),
    .head   (head),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  // back: record emitter
  tcpo_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_empty(q_empty),
    .pop    (pop),
    .q_pop  (q_pop),
    .empty  (empty),
    .rec    (rec)
  );

endmodule

// ----- hdl/tcpo_checker.sv -----
// ----------------------------------------------------------------------------
// tcpo_checker
// Port-level checks on the option parser, bound to the top level.
// ----------------------------------------------------------------------------
module tcpo_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input tcpo_pkg::opt_word_t opt,
  input logic                empty,
  input logic                pop,
  input tcpo_pkg::rec_word_t rec
);
  import tcpo_pkg::*;

  // nothing to deliver right after reset
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting word holds until taken
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rec)))
    else $error("waiting word changed before pop");

  // a summary is final exactly when it carries no sack blocks
  a_summary_final: assert property (@(posedge clk) disable iff (rst)
    (!empty && rec.record_kind == REC_SUMMARY) |->
      (rec.final_record == (rec.sack_count == '0)))
    else $error("summary final flag disagrees with sack count");

  // a non-final word is followed by a sack block word of the same segment
  a_block_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !rec.final_record) |=> (!empty && rec.record_kind == REC_BLOCK))
    else $error("segment words broken off before final word");

  // input stalls only behind an accepted word that closed an area
  a_full_after_close: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full && (opt.no_options || opt.last_byte)))
    else $error("input stalled without a closing word");

endmodule

bind tcp_option_parser_unit tcpo_checker u_tcpo_checker (
  .clk  (clk),
  .rst  (rst),
  .push (push),
  .full (full),
  .opt  (opt),
  .empty(empty),
  .pop  (pop),
  .rec  (rec)
);

// ----- sim/tcp_option_parser_unit_test.sv -----
// ----------------------------------------------------------------------------
// tcp_option_parser_unit_test
// Self-checking bench for the TCP option parser. Option areas are pushed a
// byte per word, with both sides idling at random, and every record word that
// leaves the block is checked against a behavioral parser kept in the bench.
// ----------------------------------------------------------------------------
module tcp_option_parser_unit_test;
  import tcpo_pkg::*;

  localparam int SACK_LIMIT  = 4;
  localparam int AREA_LIMIT  = 40;
  localparam int BLOCK_BYTES = 8;
  // run limit, with a wide margin over the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 10;

  // kind with no meaning to the parser, skipped by size
  localparam logic [7:0] KIND_PRIVATE = 8'd253;

  typedef enum {CLOSE_BY_LAST, CLOSE_BY_NO_OPTIONS} seg_close_t;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  opt_word_t opt;
  logic      empty;
  logic      pop;
  rec_word_t rec;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;
  int sent_items;
  int fail_count;
  int cycle_count;

  logic [7:0] seg_bytes[$];
  rec_word_t  expected_records[$];

  // parser state mirrored in the bench
  phase_t      opt_phase;
  logic [7:0]  opt_kind;
  logic [7:0]  opt_size;
  logic [5:0]  payload_idx;
  logic [7:0]  payload_buf[STORE_DEPTH];
  int          area_count;
  logic [15:0] held_mss;
  logic [3:0]  held_shift;
  logic        held_sack_ok;
  logic [2:0]  held_sack_count;
  logic [31:0] held_starts[SACK_LIMIT];
  logic [31:0] held_ends[SACK_LIMIT];
  logic [31:0] held_ts_value;
  logic [31:0] held_ts_echo;

  tcp_option_parser_unit #(
    .MAX_SACK_BLOCKS(SACK_LIMIT),
    .MAX_AREA_BYTES (AREA_LIMIT)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .opt  (opt),
    .empty(empty),
    .pop  (pop),
    .rec  (rec)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // behavioral parser
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    int i;
    opt_phase       = PH_KIND;
    opt_kind        = '0;
    opt_size        = '0;
    payload_idx     = '0;
    area_count      = 0;
    held_mss        = '0;
    held_shift      = '0;
    held_sack_ok    = 1'b0;
    held_sack_count = '0;
    held_ts_value   = '0;
    held_ts_echo    = '0;
    for (i = 0; i < STORE_DEPTH; i++) payload_buf[i] = '0;
    for (i = 0; i < SACK_LIMIT; i++) begin
      held_starts[i] = '0;
      held_ends[i]   = '0;
    end
  endfunction

  function automatic logic [31:0] payload_be32(int pos);
    return {payload_buf[pos], payload_buf[pos+1], payload_buf[pos+2], payload_buf[pos+3]};
  endfunction

  // decode a finished option, only at its exact legal size or, for sack, a whole number of blocks
  function automatic void commit_option();
    int nblk;
    int i;
    case (opt_kind)
      KIND_MSS:
        if (opt_size == SIZE_MSS) held_mss = {payload_buf[0], payload_buf[1]};
      KIND_WSCALE:
        if (opt_size == SIZE_WSCALE)
          held_shift = (payload_buf[0] > SHIFT_MAX) ? SHIFT_MAX[3:0] : payload_buf[0][3:0];
      KIND_SACK_OK:
        if (opt_size == SIZE_SACK_OK) held_sack_ok = 1'b1;
      KIND_SACK:
        if (opt_size >= SIZE_SACK_MIN && (int'(opt_size) - int'(SIZE_MIN)) % BLOCK_BYTES == 0)
        begin
          nblk = (int'(opt_size) - int'(SIZE_MIN)) / BLOCK_BYTES;
          if (nblk > SACK_LIMIT) nblk = SACK_LIMIT;
          held_sack_count = nblk[2:0];
          for (i = 0; i < nblk; i++) begin
            held_starts[i] = payload_be32(i * BLOCK_BYTES);
            held_ends[i]   = payload_be32(i * BLOCK_BYTES + 4);
          end
        end
      KIND_TSTAMP:
        if (opt_size == SIZE_TSTAMP) begin
          held_ts_value = payload_be32(0);
          held_ts_echo  = payload_be32(4);
        end
      default: ;
    endcase
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (area_count >= AREA_LIMIT) return;
    area_count++;
    case (opt_phase)
      PH_KIND: begin
        if (b == KIND_EOL) opt_phase = PH_STOPPED;
        else if (b != KIND_NOP) begin
          opt_kind  = b;
          opt_phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        opt_size    = b;
        payload_idx = '0;
        if (b < SIZE_MIN) opt_phase = PH_STOPPED;
        else if (b == SIZE_MIN) begin
          commit_option();
          opt_phase = PH_KIND;
        end else opt_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (payload_idx < STORE_DEPTH) payload_buf[payload_idx[4:0]] = b;
        payload_idx = payload_idx + 6'd1;
        if (int'(payload_idx) + int'(SIZE_MIN) == int'(opt_size)) begin
          commit_option();
          opt_phase = PH_KIND;
        end
      end
      default: ;
    endcase
  endfunction

  // one accepted word; at the end of an area queue the summary and block records
  function automatic void predict_records(opt_word_t w);
    rec_word_t r;
    int        nblk;
    int        k;
    if (!w.no_options) begin
      take_byte(w.option_byte);
      if (!w.last_byte) return;
    end
    nblk             = int'(held_sack_count);
    r                = '0;
    r.record_kind    = REC_SUMMARY;
    r.mss            = held_mss;
    r.window_shift   = held_shift;
    r.sack_permitted = held_sack_ok;
    r.sack_count     = held_sack_count;
    r.ts_value       = held_ts_value;
    r.ts_echo        = held_ts_echo;
    r.final_record   = (nblk == 0);
    expected_records.push_back(r);
    for (k = 0; k < nblk; k++) begin
      r              = '0;
      r.record_kind  = REC_BLOCK;
      r.block_start  = held_starts[k];
      r.block_end    = held_ends[k];
      r.final_record = (k + 1 == nblk);
      expected_records.push_back(r);
    end
    clear_parse();
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 50)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  task automatic check_record(rec_word_t got);
    rec_word_t want;
    if (expected_records.size() == 0) begin
      report_mismatch("record word with none expected", got.block_start, '0);
      return;
    end
    want = expected_records.pop_front();
    if (got.record_kind !== want.record_kind)
      report_mismatch("record_kind", 32'(got.record_kind), 32'(want.record_kind));
    if (got.mss !== want.mss) report_mismatch("mss", 32'(got.mss), 32'(want.mss));
    if (got.window_shift !== want.window_shift)
      report_mismatch("window_shift", 32'(got.window_shift), 32'(want.window_shift));
    if (got.sack_permitted !== want.sack_permitted)
      report_mismatch("sack_permitted", 32'(got.sack_permitted), 32'(want.sack_permitted));
    if (got.sack_count !== want.sack_count)
      report_mismatch("sack_count", 32'(got.sack_count), 32'(want.sack_count));
    if (got.ts_value !== want.ts_value) report_mismatch("ts_value", got.ts_value, want.ts_value);
    if (got.ts_echo !== want.ts_echo) report_mismatch("ts_echo", got.ts_echo, want.ts_echo);
    if (got.block_start !== want.block_start)
      report_mismatch("block_start", got.block_start, want.block_start);
    if (got.block_end !== want.block_end)
      report_mismatch("block_end", got.block_end, want.block_end);
    if (got.final_record !== want.final_record)
      report_mismatch("final_record", 32'(got.final_record), 32'(want.final_record));
  endtask

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) predict_records(opt);
      if (pop && !empty) check_record(rec);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random pops, or a counted hold-off when one is requested
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) pop = 1'b0;
      else if (hold_off > 0) begin
        pop = 1'b0;
        hold_off--;
      end else pop = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_word(opt_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    opt  = w;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_items++;
  endtask

  // option bytes: kind, size, then size-2 payload bytes
  function automatic void add_option(logic [7:0] kind, logic [7:0] size,
                                     bit random_fill = 1'b1, logic [31:0] pattern = '0);
    int i;
    seg_bytes.push_back(kind);
    seg_bytes.push_back(size);
    for (i = 0; i < int'(size) - int'(SIZE_MIN); i++)
      seg_bytes.push_back(random_fill ? 8'($urandom) : pattern[8*(3 - i % 4) +: 8]);
  endfunction

  task automatic send_segment(seg_close_t how);
    opt_word_t w;
    int        i;
    for (i = 0; i < seg_bytes.size(); i++) begin
      w.option_byte = seg_bytes[i];
      w.last_byte   = (how == CLOSE_BY_LAST) && (i == seg_bytes.size() - 1);
      w.no_options  = 1'b0;
      send_word(w);
    end
    if (how == CLOSE_BY_NO_OPTIONS) begin
      w.option_byte = 8'($urandom);
      w.last_byte   = 1'($urandom_range(1));
      w.no_options  = 1'b1;
      send_word(w);
    end
    seg_bytes.delete();
  endtask

  // sender pause: stop offering words until every record is back
  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic build_random_segment();
    int shape;
    int nblk;
    int cut;
    logic [7:0] kind;
    shape = $urandom_range(99);
    if (shape < 70) begin
      // option lists with random content, including wrong sizes and eol
      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(8))
          0: seg_bytes.push_back(KIND_NOP);
          1: add_option(KIND_MSS, SIZE_MSS);
          2: add_option(KIND_WSCALE, SIZE_WSCALE);
          3: add_option(KIND_SACK_OK, SIZE_SACK_OK);
          4: begin
            nblk = $urandom_range(SACK_LIMIT, 1);
            add_option(KIND_SACK, SIZE_SACK_MIN + 8'(BLOCK_BYTES * (nblk - 1)));
          end
          5: add_option(KIND_TSTAMP, SIZE_TSTAMP);
          6: begin
            kind = 8'($urandom_range(255, 6));
            if (kind == KIND_TSTAMP) kind = KIND_PRIVATE;
            add_option(kind, 8'($urandom_range(12, 2)));
          end
          7: begin
            seg_bytes.push_back(KIND_EOL);
            repeat ($urandom_range(3)) seg_bytes.push_back(8'($urandom));
          end
          default: begin
            case ($urandom_range(4))
              0: kind = KIND_MSS;
              1: kind = KIND_WSCALE;
              2: kind = KIND_SACK_OK;
              3: kind = KIND_SACK;
              default: kind = KIND_TSTAMP;
            endcase
            add_option(kind, 8'($urandom_range(12, 2)));
          end
        endcase
      end
    end else if (shape < 85) begin
      // noise
      repeat ($urandom_range(48, 1)) seg_bytes.push_back(8'($urandom));
    end else begin
      // option cut short by the end of the area
      if ($urandom_range(1)) add_option(KIND_TSTAMP, SIZE_TSTAMP);
      else add_option(KIND_SACK, SIZE_SACK_MIN + 8'(BLOCK_BYTES));
      cut = $urandom_range(seg_bytes.size() - 1, 1);
      repeat (cut) void'(seg_bytes.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_empty_area();
    send_segment(CLOSE_BY_NO_OPTIONS);
    send_segment(CLOSE_BY_NO_OPTIONS);
  endtask

  task automatic test_each_option();
    seg_bytes.push_back(KIND_NOP);
    add_option(KIND_MSS, SIZE_MSS, 1'b0, 32'hFFFF_FFFF);
    add_option(KIND_WSCALE, SIZE_WSCALE, 1'b0, 32'hFFFF_FFFF);
    add_option(KIND_SACK_OK, SIZE_SACK_OK);
    add_option(KIND_TSTAMP, SIZE_TSTAMP, 1'b0, 32'hFFFF_FFFF);
    send_segment(CLOSE_BY_LAST);
  endtask

  // low extremes, shift clamp edge and a later option overwriting an earlier one
  task automatic test_low_extremes_and_overwrite();
    add_option(KIND_MSS, SIZE_MSS, 1'b0, 32'h0);
    add_option(KIND_WSCALE, SIZE_WSCALE, 1'b0, 32'h0);
    add_option(KIND_TSTAMP, SIZE_TSTAMP, 1'b0, 32'h0);
    send_segment(CLOSE_BY_LAST);
    add_option(KIND_MSS, SIZE_MSS, 1'b0, 32'h0);
    add_option(KIND_MSS, SIZE_MSS, 1'b0, 32'h1234_5678);
    add_option(KIND_WSCALE, SIZE_WSCALE, 1'b0, 32'h0F0F_0F0F);
    send_segment(CLOSE_BY_LAST);
    add_option(KIND_WSCALE, SIZE_WSCALE, 1'b0, 32'h0E0E_0E0E);
    send_segment(CLOSE_BY_LAST);
  endtask

  task automatic test_sack_blocks();
    add_option(KIND_SACK, SIZE_SACK_MIN + 8'(BLOCK_BYTES * (SACK_LIMIT - 1)));
    send_segment(CLOSE_BY_LAST);
    add_option(KIND_SACK, SIZE_SACK_MIN + 8'(BLOCK_BYTES));
    add_option(KIND_SACK, SIZE_SACK_MIN);
    send_segment(CLOSE_BY_LAST);
  endtask

  // eol, size below two: everything after is ignored
  task automatic test_parse_stops();
    add_option(KIND_MSS, SIZE_MSS);
    seg_bytes.push_back(KIND_EOL);
    add_option(KIND_WSCALE, SIZE_WSCALE);
    send_segment(CLOSE_BY_LAST);
    add_option(KIND_MSS, SIZE_MSS);
    add_option(KIND_WSCALE, SIZE_MIN - 8'd1);
    add_option(KIND_SACK_OK, SIZE_SACK_OK);
    send_segment(CLOSE_BY_LAST);
    add_option(KIND_TSTAMP, 8'd0);
    send_segment(CLOSE_BY_LAST);
  endtask

  // options still missing bytes at the end of the area are dropped
  task automatic test_cut_off();
    add_option(KIND_SACK_OK, SIZE_SACK_OK);
    add_option(KIND_TSTAMP, SIZE_TSTAMP);
    repeat (5) void'(seg_bytes.pop_back());
    send_segment(CLOSE_BY_LAST);
    seg_bytes.push_back(KIND_MSS);
    send_segment(CLOSE_BY_LAST);
    // more sack blocks than the area can carry
    add_option(KIND_SACK, SIZE_SACK_MIN + 8'(BLOCK_BYTES * SACK_LIMIT));
    send_segment(CLOSE_BY_LAST);
  endtask

  // bytes past the area limit are ignored, but their last flag still counts
  task automatic test_excess_bytes();
    repeat (AREA_LIMIT - 2) seg_bytes.push_back(KIND_NOP);
    add_option(KIND_MSS, SIZE_MSS);
    repeat (3) seg_bytes.push_back(8'($urandom));
    send_segment(CLOSE_BY_LAST);
  endtask

  // payload longer than the store, then a short option that still fits
  task automatic test_long_payload();
    add_option(KIND_PRIVATE, 8'(AREA_LIMIT - 2));
    add_option(KIND_SACK_OK, SIZE_SACK_OK);
    send_segment(CLOSE_BY_LAST);
  endtask

  // a malformed sack leaves the earlier one in place
  task automatic test_malformed_sack();
    add_option(KIND_SACK, SIZE_SACK_MIN);
    add_option(KIND_SACK, SIZE_SACK_MIN + 8'd1);
    send_segment(CLOSE_BY_LAST);
  endtask

  task automatic test_no_options_mid_area();
    add_option(KIND_MSS, SIZE_MSS);
    add_option(KIND_SACK, SIZE_SACK_MIN);
    repeat (5) void'(seg_bytes.pop_back());
    send_segment(CLOSE_BY_NO_OPTIONS);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start         = sent_items;
    while (sent_items - start < count) begin
      build_random_segment();
      send_segment(($urandom_range(99) < 80) ? CLOSE_BY_LAST : CLOSE_BY_NO_OPTIONS);
    end
    wait_drained();
  endtask

  // receiver stalls long enough for the segment queue to fill and push to stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_off      = 80;
    repeat (4) begin
      add_option(KIND_MSS, SIZE_MSS);
      add_option(KIND_SACK, SIZE_SACK_MIN);
      send_segment(CLOSE_BY_LAST);
    end
    wait_drained();
  endtask

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    opt           = '0;
    send_idle_pct = 38;
    recv_idle_pct = 68;
    hold_off      = 0;
    sent_items    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    clear_parse();
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_empty_area();
    test_each_option();
    test_low_extremes_and_overwrite();
    test_sack_blocks();
    test_parse_stops();
    test_cut_off();
    test_excess_bytes();
    test_long_payload();
    test_malformed_sack();
    test_no_options_mid_area();
    wait_drained();

    test_random_traffic(38, 68, 10);
    test_random_traffic(68, 38, 10);
    test_random_traffic(0, 0, 10);
    test_backpressure();

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tcpo_pkg.sv
hdl/tcpo_parse.sv
hdl/tcpo_hold.sv
hdl/tcpo_queue.sv
hdl/tcpo_back.sv
hdl/tcp_option_parser_unit.sv
hdl/tcpo_checker.sv
sim/tcp_option_parser_unit_test.sv
